// ===== src/cmpr_pkg.sv =====
// Shared types and constants for the cursor mask to premultiplied RGBA block.
// Holds the request and result structs, the controller states and the
// command and status groups between the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package cmpr_pkg;

	localparam int READ_INDEX_W = 12;
	localparam int READ_SPAN    = 2 ** READ_INDEX_W;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
	localparam logic [CFG_DATA_W-1:0]  SIZE_RESET       = 7'd32;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic [31:0] PIX_BLACK = 32'hFF00_0000;
	localparam logic [31:0] PIX_WHITE = 32'hFFFF_FFFF;
	localparam logic [31:0] PIX_CLEAR = 32'h0000_0000;

	typedef struct packed {
		logic                    action;
		logic                    mask_bit;
		logic [31:0]             color_pixel;
		logic                    last_pixel;
		logic [READ_INDEX_W-1:0] read_index;
	} request_t;

	typedef struct packed {
		logic [31:0] pixel_out;
		logic        alpha_found;
		logic        outline_added;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MOD,
		ST_RD_ISSUE,
		ST_RD_DATA,
		ST_SETUP,
		ST_MUL,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_CMB_RD,
		ST_CMB_WR,
		ST_OUT_RD,
		ST_OUT_CHK,
		ST_NB_ADDR,
		ST_NB_CHK,
		ST_PM_RD,
		ST_PM_MUL,
		ST_PM_WR
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_capture;
		logic mod_step;
		logic rd_issue;
		logic result_load;
		logic setup;
		logic mul;
		logic pass_clear;
		logic advance;
		logic rd_center;
		logic rd_nb;
		logic nb_clear;
		logic nb_next;
		logic scan_chk;
		logic cmb_wr;
		logic white_wr;
		logic pm_mul;
		logic pm_wr;
	} cmd_t;

	typedef struct packed {
		logic mod_last;
		logic last_pix;
		logic alpha_any;
		logic outline_any;
		logic center_clear;
		logic nb_valid;
		logic nb_last;
		logic nb_black;
	} status_t;

endpackage

`default_nettype wire

// ===== src/cmpr_ctrl.sv =====
// Controller state machine: sequences loads, reads and the four image passes.
// Depends on cmpr_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module cmpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              action,
	input  logic              last_pixel,
	input  cmpr_pkg::status_t status,
	output cmpr_pkg::cmd_t    cmd,
	output logic              busy
);
	import cmpr_pkg::*;

	state_t state_q;
	state_t state_next;
	state_t after_outline_px;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// Where the outline pass goes once the current pixel is finished.
	assign after_outline_px = status.last_pix ? ST_PM_RD : ST_OUT_RD;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action == ACT_READ) begin
						state_next = ST_MOD;
					end else if (last_pixel) begin
						state_next = ST_SETUP;
					end
				end
			end
			ST_MOD: begin
				if (status.mod_last) begin
					state_next = ST_RD_ISSUE;
				end
			end
			ST_RD_ISSUE: state_next = ST_RD_DATA;
			ST_RD_DATA:  state_next = ST_IDLE;
			ST_SETUP:    state_next = ST_MUL;
			ST_MUL:      state_next = ST_SCAN_RD;
			ST_SCAN_RD:  state_next = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (!status.last_pix) begin
					state_next = ST_SCAN_RD;
				end else if (status.alpha_any) begin
					state_next = ST_PM_RD;
				end else begin
					state_next = ST_CMB_RD;
				end
			end
			ST_CMB_RD: state_next = ST_CMB_WR;
			ST_CMB_WR: begin
				if (!status.last_pix) begin
					state_next = ST_CMB_RD;
				end else if (status.outline_any) begin
					state_next = ST_OUT_RD;
				end else begin
					state_next = ST_PM_RD;
				end
			end
			ST_OUT_RD: state_next = ST_OUT_CHK;
			ST_OUT_CHK: begin
				if (status.center_clear) begin
					state_next = ST_NB_ADDR;
				end else begin
					state_next = after_outline_px;
				end
			end
			ST_NB_ADDR: begin
				if (status.nb_valid) begin
					state_next = ST_NB_CHK;
				end else if (status.nb_last) begin
					state_next = after_outline_px;
				end
			end
			ST_NB_CHK: begin
				if (status.nb_black || status.nb_last) begin
					state_next = after_outline_px;
				end else begin
					state_next = ST_NB_ADDR;
				end
			end
			ST_PM_RD:  state_next = ST_PM_MUL;
			ST_PM_MUL: state_next = ST_PM_WR;
			ST_PM_WR: begin
				if (status.last_pix) begin
					state_next = ST_IDLE;
				end else begin
					state_next = ST_PM_RD;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action == ACT_READ) begin
						cmd.rd_capture = 1'b1;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_MOD:      cmd.mod_step = 1'b1;
			ST_RD_ISSUE: cmd.rd_issue = 1'b1;
			ST_RD_DATA:  cmd.result_load = 1'b1;
			ST_SETUP:    cmd.setup = 1'b1;
			ST_MUL: begin
				cmd.mul = 1'b1;
				cmd.pass_clear = 1'b1;
			end
			ST_SCAN_RD: cmd.rd_center = 1'b1;
			ST_SCAN_CHK: begin
				cmd.scan_chk = 1'b1;
				cmd.pass_clear = status.last_pix;
				cmd.advance = !status.last_pix;
			end
			ST_CMB_RD: cmd.rd_center = 1'b1;
			ST_CMB_WR: begin
				cmd.cmb_wr = 1'b1;
				cmd.pass_clear = status.last_pix;
				cmd.advance = !status.last_pix;
			end
			ST_OUT_RD: begin
				cmd.rd_center = 1'b1;
				cmd.nb_clear = 1'b1;
			end
			ST_OUT_CHK: begin
				if (!status.center_clear) begin
					cmd.pass_clear = status.last_pix;
					cmd.advance = !status.last_pix;
				end
			end
			ST_NB_ADDR: begin
				if (status.nb_valid) begin
					cmd.rd_nb = 1'b1;
				end else if (status.nb_last) begin
					cmd.pass_clear = status.last_pix;
					cmd.advance = !status.last_pix;
				end else begin
					cmd.nb_next = 1'b1;
				end
			end
			ST_NB_CHK: begin
				if (status.nb_black || status.nb_last) begin
					cmd.white_wr = status.nb_black;
					cmd.pass_clear = status.last_pix;
					cmd.advance = !status.last_pix;
				end else begin
					cmd.nb_next = 1'b1;
				end
			end
			ST_PM_RD:  cmd.rd_center = 1'b1;
			ST_PM_MUL: cmd.pm_mul = 1'b1;
			ST_PM_WR: begin
				cmd.pm_wr = 1'b1;
				cmd.pass_clear = status.last_pix;
				cmd.advance = !status.last_pix;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/cmpr_datapath.sv =====
// Datapath: image store, load counter, index reduction, pass counters,
// pixel rules, premultiply pipeline and the result register.
// Depends on cmpr_pkg; driven by cmpr_ctrl through the command group.
`timescale 1ns / 1ps
`default_nettype none

module cmpr_datapath #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cmpr_pkg::cmd_t                       cmd,
	output cmpr_pkg::status_t                    status,
	input  cmpr_pkg::request_t                   req,
	input  logic                                 cfg_we,
	input  logic [cmpr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cmpr_pkg::CFG_DATA_W-1:0]      cfg_data,
	output cmpr_pkg::result_t                    result,
	output logic                                 result_valid
);
	import cmpr_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = AW + 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int PW    = WW + HW;

	localparam logic [1:0] NB_UP    = 2'd0;
	localparam logic [1:0] NB_DOWN  = 2'd1;
	localparam logic [1:0] NB_LEFT  = 2'd2;
	localparam logic [1:0] NB_RIGHT = 2'd3;

	// Largest shift k with (DEPTH << k) still inside the read index range.
	function automatic int mod_top_shift(input int depth);
		int k;
		k = 0;
		while (k < 16 && (depth << (k + 1)) <= READ_SPAN - 1) begin
			k = k + 1;
		end
		return k;
	endfunction

	localparam int MOD_TOP = mod_top_shift(DEPTH);
	localparam int KW      = (MOD_TOP > 0) ? $clog2(MOD_TOP + 1) : 1;

	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = 17'(x) + 17'(x >> 8) + 17'd1;
		return s[15:8];
	endfunction

	logic [31:0]             pix_mem [DEPTH];
	logic                    mask_mem [DEPTH];

	logic [CFG_DATA_W-1:0]   cfg_width_q;
	logic [CFG_DATA_W-1:0]   cfg_height_q;
	logic [AW-1:0]           load_count_q;
	logic                    alpha_seen_q;
	logic                    outline_q;
	logic [WW-1:0]           w_q;
	logic [HW-1:0]           h_q;
	logic [NW-1:0]           n_q;
	logic [AW-1:0]           idx_q;
	logic [WW-1:0]           x_q;
	logic [HW-1:0]           y_q;
	logic [1:0]              nb_q;
	logic [READ_INDEX_W-1:0] rem_q;
	logic [KW-1:0]           mod_k_q;
	logic [31:0]             pix_rd_q;
	logic                    mask_rd_q;
	logic [15:0]             prod_r_s1;
	logic [15:0]             prod_g_s1;
	logic [15:0]             prod_b_s1;
	logic [7:0]              alpha_s1;
	result_t                 result_q;
	logic                    result_valid_q;

	logic [WW-1:0]           w_clamp;
	logic [HW-1:0]           h_clamp;
	logic [PW-1:0]           size_prod;
	logic [31:0]             mod_sub;
	logic                    mod_ge;
	logic [AW-1:0]           nb_addr;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [31:0]             wr_data;
	logic [31:0]             cmb_pix;
	logic                    cmb_outline;
	logic [31:0]             pm_pix;
	logic                    nb_valid;

	// Size registers read as 1 when zero and saturate at the maximum.
	always_comb begin
		if (cfg_width_q == '0) begin
			w_clamp = WW'(1);
		end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = WW'(cfg_width_q);
		end
		if (cfg_height_q == '0) begin
			h_clamp = HW'(1);
		end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
			h_clamp = HW'(MAX_HEIGHT);
		end else begin
			h_clamp = HW'(cfg_height_q);
		end
	end

	assign size_prod = PW'(w_q) * PW'(h_q);

	// One restoring step of the read index reduction modulo the store depth.
	assign mod_sub = 32'(DEPTH) << mod_k_q;
	assign mod_ge  = (32'(rem_q) >= mod_sub);

	always_comb begin
		unique case (nb_q)
			NB_UP:    nb_addr = idx_q - AW'(w_q);
			NB_DOWN:  nb_addr = idx_q + AW'(w_q);
			NB_LEFT:  nb_addr = idx_q - AW'(1);
			NB_RIGHT: nb_addr = idx_q + AW'(1);
			default:  nb_addr = idx_q;
		endcase
	end

	always_comb begin
		priority if (cmd.rd_issue) begin
			rd_addr = AW'(rem_q);
		end else if (cmd.rd_nb) begin
			rd_addr = nb_addr;
		end else begin
			rd_addr = idx_q;
		end
	end

	// Combine rule for images without their own alpha.
	always_comb begin
		cmb_outline = 1'b0;
		if (mask_rd_q) begin
			if (pix_rd_q != PIX_CLEAR) begin
				cmb_pix = PIX_BLACK;
				cmb_outline = 1'b1;
			end else begin
				cmb_pix = PIX_CLEAR;
			end
		end else begin
			cmb_pix = pix_rd_q ^ PIX_BLACK;
		end
	end

	assign pm_pix = {alpha_s1, div255(prod_b_s1), div255(prod_g_s1), div255(prod_r_s1)};

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = idx_q;
		wr_data = pm_pix;
		priority if (cmd.load) begin
			wr_addr = load_count_q;
			wr_data = req.color_pixel;
		end else if (cmd.cmb_wr) begin
			wr_data = cmb_pix;
		end else if (cmd.white_wr) begin
			wr_data = PIX_WHITE;
		end else if (cmd.pm_wr) begin
			wr_data = pm_pix;
		end else begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pix_mem[wr_addr] <= wr_data;
		end
		if (cmd.load) begin
			mask_mem[load_count_q] <= req.mask_bit;
		end
		if (cmd.rd_issue || cmd.rd_nb || cmd.rd_center) begin
			pix_rd_q  <= pix_mem[rd_addr];
			mask_rd_q <= mask_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q    <= SIZE_RESET;
			cfg_height_q   <= SIZE_RESET;
			load_count_q   <= '0;
			alpha_seen_q   <= 1'b0;
			outline_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_IMAGE_WIDTH) begin
				cfg_width_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_IMAGE_HEIGHT) begin
				cfg_height_q <= cfg_data;
			end
			if (cmd.load) begin
				if (req.last_pixel || load_count_q == AW'(DEPTH - 1)) begin
					load_count_q <= '0;
				end else begin
					load_count_q <= load_count_q + AW'(1);
				end
			end
			if (cmd.setup) begin
				alpha_seen_q <= 1'b0;
				outline_q    <= 1'b0;
			end else begin
				if (cmd.scan_chk && pix_rd_q[31:24] != 8'd0) begin
					alpha_seen_q <= 1'b1;
				end
				if (cmd.cmb_wr && cmb_outline) begin
					outline_q <= 1'b1;
				end
			end
			result_valid_q <= cmd.result_load;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			w_q <= w_clamp;
			h_q <= h_clamp;
		end
		if (cmd.mul) begin
			n_q <= NW'(size_prod);
		end
		if (cmd.pass_clear) begin
			idx_q <= '0;
			x_q   <= '0;
			y_q   <= '0;
		end else if (cmd.advance) begin
			idx_q <= idx_q + AW'(1);
			if (x_q + WW'(1) == w_q) begin
				x_q <= '0;
				y_q <= y_q + HW'(1);
			end else begin
				x_q <= x_q + WW'(1);
			end
		end
		if (cmd.nb_clear) begin
			nb_q <= NB_UP;
		end else if (cmd.nb_next) begin
			nb_q <= nb_q + 2'd1;
		end
		if (cmd.rd_capture) begin
			rem_q   <= req.read_index;
			mod_k_q <= KW'(MOD_TOP);
		end else if (cmd.mod_step) begin
			if (mod_ge) begin
				rem_q <= rem_q - mod_sub[READ_INDEX_W-1:0];
			end
			if (mod_k_q != '0) begin
				mod_k_q <= mod_k_q - KW'(1);
			end
		end
		if (cmd.pm_mul) begin
			prod_r_s1 <= 16'(pix_rd_q[7:0]) * 16'(pix_rd_q[31:24]);
			prod_g_s1 <= 16'(pix_rd_q[15:8]) * 16'(pix_rd_q[31:24]);
			prod_b_s1 <= 16'(pix_rd_q[23:16]) * 16'(pix_rd_q[31:24]);
			alpha_s1  <= pix_rd_q[31:24];
		end
		if (cmd.result_load) begin
			result_q.pixel_out     <= pix_rd_q;
			result_q.alpha_found   <= alpha_seen_q;
			result_q.outline_added <= outline_q;
		end
	end

	always_comb begin
		unique case (nb_q)
			NB_UP:    nb_valid = (y_q != '0);
			NB_DOWN:  nb_valid = (y_q + HW'(1) != h_q);
			NB_LEFT:  nb_valid = (x_q != '0);
			NB_RIGHT: nb_valid = (x_q + WW'(1) != w_q);
			default:  nb_valid = 1'b0;
		endcase
	end

	// Fields in the order of status_t.
	assign status = {
		(mod_k_q == '0),
		((NW'(idx_q) + NW'(1)) == n_q),
		(alpha_seen_q || (pix_rd_q[31:24] != 8'd0)),
		(outline_q || cmb_outline),
		(pix_rd_q == PIX_CLEAR),
		nb_valid,
		(nb_q == NB_RIGHT),
		(pix_rd_q == PIX_BLACK)
	};

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

// ===== src/cursor_mask_to_premultiplied_rgba.sv =====
// A plain load leaves busy low. Read: the result strobe is high for one cycle, after the
// index reduction, the store read and the result register, in that order.
// A last-pixel load holds busy through the scan, combine (skipped on alpha), outline
// (only if combine adds one) and premultiply passes over n = width * height pixels.
// Reset clears the sizes to 32, the load counter and both flags; the store holds
// no defined data until loaded, and there is no clearing pass. Results cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module cursor_mask_to_premultiplied_rgba #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  cmpr_pkg::request_t               request,
	output cmpr_pkg::result_t                result,
	output logic                             result_valid,
	input  logic                             cfg_we,
	input  logic [cmpr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cmpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cmpr_pkg::*;

	cmd_t    cmd;
	status_t status;

	cmpr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.action     (request.action),
		.last_pixel (request.last_pixel),
		.status     (status),
		.cmd        (cmd),
		.busy       (busy)
	);

	cmpr_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req          (request),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result       (result),
		.result_valid (result_valid)
	);

`ifndef SYNTHESIS
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result presented while the block is busy");

	a_load_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.action == ACT_LOAD && !request.last_pixel) |=> !busy)
		else $error("plain load request made the block busy");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.action == ACT_READ) |=> busy)
		else $error("read request did not start a read sequence");
`endif

endmodule

`default_nettype wire
